### hw/rtl/pgf_pkg.sv
// Package: shared constants, action codes and types for polygon ground flattening.
package pgf_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int COORD_W      = 32;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int PROD_W       = 2 * DIFF_W;
  localparam int IN_DATA_W    = 96;
  localparam int IN_USER_W    = 2;
  localparam int OUT_DATA_W   = 40;
  localparam int DRAIN_CYC    = 2;
  localparam int DRAIN_W      = 2;

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_TEST  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } corner_t;

  typedef struct packed {
    logic start;
    logic valid;
  } edge_ctl_t;

endpackage

### hw/rtl/pgf_cell.sv
// Corner cell: one stored polygon corner, shifted on to the next cell when enabled.
module pgf_cell (
  input  logic             clk,
  input  logic             shift_en,
  input  pgf_pkg::corner_t d,
  output pgf_pkg::corner_t q
);
  import pgf_pkg::*;

  corner_t corner_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      corner_r <= d;
    end
  end

  assign q = corner_r;

endmodule

### hw/rtl/pgf_edge.sv
// Edge unit: three-stage crossing test of one polygon edge per cycle, parity accumulator.
module pgf_edge (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pgf_pkg::edge_ctl_t                ctl,
  input  pgf_pkg::corner_t                  cur,
  input  pgf_pkg::corner_t                  prev,
  input  logic signed [pgf_pkg::COORD_W-1:0] px,
  input  logic signed [pgf_pkg::COORD_W-1:0] py,
  output logic                              parity
);
  import pgf_pkg::*;

  logic                     s1_valid_r;
  logic signed [DIFF_W-1:0] s1_d1_r, s1_d2_r, s1_d3_r, s1_dy_r;
  logic                     s2_valid_r;
  logic                     s2_dypos_r;
  logic signed [PROD_W-1:0] s2_lhs_r, s2_rhs_r;
  logic                     parity_r;

  logic straddle, xcond, left_of;

  assign straddle = (cur.y < py && prev.y >= py) || (prev.y < py && cur.y >= py);
  assign xcond    = (cur.x <= px) || (prev.x <= px);
  assign left_of  = s2_dypos_r ? (s2_lhs_r < s2_rhs_r) : (s2_rhs_r < s2_lhs_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      parity_r   <= 1'b0;
    end else begin
      s1_valid_r <= ctl.valid && straddle && xcond;
      s2_valid_r <= s1_valid_r;
      if (ctl.start) begin
        parity_r <= 1'b0;
      end else if (s2_valid_r && left_of) begin
        parity_r <= ~parity_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_d1_r    <= DIFF_W'(py) - DIFF_W'(cur.y);
    s1_d2_r    <= DIFF_W'(prev.x) - DIFF_W'(cur.x);
    s1_d3_r    <= DIFF_W'(px) - DIFF_W'(cur.x);
    s1_dy_r    <= DIFF_W'(prev.y) - DIFF_W'(cur.y);
    s2_lhs_r   <= PROD_W'(s1_d1_r) * PROD_W'(s1_d2_r);
    s2_rhs_r   <= PROD_W'(s1_d3_r) * PROD_W'(s1_dy_r);
    s2_dypos_r <= s1_dy_r > 0;
  end

  assign parity = parity_r;

endmodule

### hw/rtl/polygon_ground_flattening.sv
// Top level: corner cell ring, edge unit, control and output register.
//
//  channel | dir | ports                         | content
//  in      | in  | in_tvalid/in_tready/in_tdata  | tuser: action; tdata: x, y, z
//  out     | out | out_tvalid/out_tready/out_tdata | tdata: inside_res, height_out, status
//
// Clear and add present their result in the cycle after the transfer.
// A test rotates the whole ring once, handing one edge per shift to the edge unit,
// then drains the edge unit before the result is registered.
// Reset empties the polygon; stored corners need no clearing.
// Input is taken only when idle and the output register is free or being drained.
module polygon_ground_flattening (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [pgf_pkg::IN_USER_W-1:0]     in_tuser,   // [1:0] action
  input  logic [pgf_pkg::IN_DATA_W-1:0]     in_tdata,   // [31:0] coord_x, [63:32] coord_y,
                                                        // [95:64] coord_z
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [pgf_pkg::OUT_DATA_W-1:0]    out_tdata   // [0] inside_res, [32:1] height_out,
                                                        // [33] status, [39:34] zero
);
  import pgf_pkg::*;

  state_t                     state_r, state_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic signed [COORD_W-1:0]  low_r, low_nxt;
  logic [IDX_W-1:0]           scan_r, scan_nxt;
  logic [DRAIN_W-1:0]         drain_r, drain_nxt;
  logic signed [COORD_W-1:0]  px_r, py_r, pz_r;
  corner_t                    prev_r;
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_inside_r, out_inside_nxt;
  logic signed [COORD_W-1:0]  out_height_r, out_height_nxt;
  logic                       out_status_r, out_status_nxt;

  logic                       in_xfer, out_free, shift_en, load_pt, active;
  logic signed [COORD_W-1:0]  in_x, in_y, in_z;
  action_t                    act;
  corner_t                    cell_d [MAX_VERTICES];
  corner_t                    cell_q [MAX_VERTICES];
  corner_t                    new_corner;
  edge_ctl_t                  ectl;
  logic                       parity;
  logic [CNT_W-1:0]           thresh;

  assign in_x     = in_tdata[31:0];
  assign in_y     = in_tdata[63:32];
  assign in_z     = in_tdata[95:64];
  assign act      = action_t'(in_tuser);
  assign out_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign in_xfer  = in_tvalid && in_tready;
  assign new_corner = '{x: in_x, y: in_y};
  assign thresh   = CNT_W'(MAX_VERTICES) - count_r;
  assign active   = CNT_W'(scan_r) >= thresh;

  genvar k;
  generate
    for (k = 0; k < MAX_VERTICES; k++) begin : g_cell
      if (k == 0) begin : g_head
        assign cell_d[k] = (state_r == ST_SCAN) ? cell_q[MAX_VERTICES-1] : new_corner;
      end else begin : g_body
        assign cell_d[k] = cell_q[k-1];
      end
      pgf_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .d        (cell_d[k]),
        .q        (cell_q[k])
      );
    end
  endgenerate

  assign ectl = '{start: load_pt, valid: (state_r == ST_SCAN) && active};

  pgf_edge u_edge (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ectl),
    .cur    (cell_q[MAX_VERTICES-1]),
    .prev   (prev_r),
    .px     (px_r),
    .py     (py_r),
    .parity (parity)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    low_nxt        = low_r;
    scan_nxt       = scan_r;
    drain_nxt      = drain_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_inside_nxt = out_inside_r;
    out_height_nxt = out_height_r;
    out_status_nxt = out_status_r;
    shift_en       = 1'b0;
    load_pt        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          out_inside_nxt = 1'b0;
          out_height_nxt = '0;
          out_status_nxt = 1'b0;
          case (act)
            ACT_CLEAR: begin
              count_nxt     = '0;
              low_nxt       = COORD_MAX;
              out_valid_nxt = 1'b1;
            end
            ACT_ADD: begin
              out_valid_nxt = 1'b1;
              if (count_r < CNT_W'(MAX_VERTICES)) begin
                shift_en  = 1'b1;
                count_nxt = count_r + 1'b1;
                if (in_z < low_r) begin
                  low_nxt = in_z;
                end
              end else begin
                out_status_nxt = 1'b1;
              end
            end
            ACT_TEST: begin
              load_pt   = 1'b1;
              scan_nxt  = '0;
              state_nxt = ST_SCAN;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        shift_en = 1'b1;
        scan_nxt = scan_r + 1'b1;
        if (scan_r == IDX_W'(MAX_VERTICES - 1)) begin
          drain_nxt = '0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        drain_nxt = drain_r + 1'b1;
        if (drain_r == DRAIN_W'(DRAIN_CYC)) begin
          out_valid_nxt  = 1'b1;
          out_inside_nxt = parity;
          out_status_nxt = 1'b0;
          if (parity) begin
            out_height_nxt = (low_r == COORD_MIN) ? COORD_MIN : low_r - 1'b1;
          end else begin
            out_height_nxt = pz_r;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      low_r       <= COORD_MAX;
      scan_r      <= '0;
      drain_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      low_r       <= low_nxt;
      scan_r      <= scan_nxt;
      drain_r     <= drain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_inside_r <= out_inside_nxt;
    out_height_r <= out_height_nxt;
    out_status_r <= out_status_nxt;
    if (load_pt) begin
      px_r   <= in_x;
      py_r   <= in_y;
      pz_r   <= in_z;
      prev_r <= cell_q[0];
    end else if (state_r == ST_SCAN && active) begin
      prev_r <= cell_q[MAX_VERTICES-1];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_status_r, out_height_r, out_inside_r};

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_VERTICES))
    else $error("corner count beyond table size");

  a_out_empty_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> !out_valid_r)
    else $error("output register busy during a scan");

  a_scan_starts_zero: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == ST_SCAN) |-> scan_r == '0)
    else $error("scan started at a nonzero position");

  a_inside_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_inside_r && out_status_r))
    else $error("inside result with dropped status");

endmodule
